>>> rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// PPG beat detector package
// Shared widths, reset constants, register codes and the command and status
// words between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int RAW_BITS    = 18;
  localparam int MS_BITS     = 16;
  localparam int RATE_BITS   = 16;
  localparam int RISE_BITS   = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS    = RATE_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [RAW_BITS-1:0]           raw_t;
  typedef logic [MS_BITS-1:0]            ms_t;
  typedef logic [RATE_BITS-1:0]          rate_t;
  typedef logic [RISE_BITS-1:0]          rise_t;

  localparam raw_t    THRESH_RESET  = raw_t'(100000);
  localparam sample_t CREST_RESET   = sample_t'(100);
  localparam sample_t TROUGH_RESET  = sample_t'(-100);
  localparam rise_t   RISE_RESET    = rise_t'(2);
  localparam sample_t RUN_MAX_INIT  = sample_t'(-9999);
  localparam sample_t RUN_MIN_INIT  = sample_t'(9999);
  localparam rate_t   RATE_DIVIDEND = rate_t'(60000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FINGER_THRESHOLD = 2'd0,
    CFG_CREST_LEVEL      = 2'd1,
    CFG_TROUGH_LEVEL     = 2'd2,
    CFG_RISE_NEEDED      = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic div_last;
    logic load_out;
  } pbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } pbd_sts_t;

endpackage

>>> rtl/pbd_if.sv
// ----------------------------------------------------------------------------
// PPG beat detector channels
// Sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbd_in_if;
  import pbd_pkg::*;

  logic    valid;
  logic    ready;
  raw_t    raw_ir;
  sample_t filtered_ir;
  ms_t     elapsed_ms;

  modport source (output valid, raw_ir, filtered_ir, elapsed_ms, input ready);
  modport sink   (input valid, raw_ir, filtered_ir, elapsed_ms, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;

  logic  valid;
  logic  ready;
  logic  finger_present;
  logic  beat;
  rate_t beat_rate;
  logic  rate_valid;

  modport source (output valid, finger_present, beat, beat_rate, rate_valid, input ready);
  modport sink   (input valid, finger_present, beat, beat_rate, rate_valid, output ready);
endinterface

>>> rtl/pbd_datapath.sv
// ----------------------------------------------------------------------------
// PPG beat detector datapath
// Configuration registers, crest/trough detection state, restoring divider
// for the rate and the result register.
// ----------------------------------------------------------------------------
module pbd_datapath import pbd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  raw_t                     in_raw_ir,
  input  sample_t                  in_filtered_ir,
  input  ms_t                      in_elapsed_ms,
  input  pbd_cmd_t                 cmd,
  output pbd_sts_t                 sts,
  output logic                     out_finger_present,
  output logic                     out_beat,
  output rate_t                    out_beat_rate,
  output logic                     out_rate_valid
);

  // Configuration
  raw_t    thresh_r;
  sample_t crest_lvl_r, trough_lvl_r;
  rise_t   rise_need_r;

  // Captured word
  raw_t    raw_r;
  sample_t data_r;
  ms_t     elapsed_r;

  // Detection state
  sample_t prev_r, prev_nxt;
  logic    prev_valid_r, prev_valid_nxt;
  logic    crest_r, crest_nxt;
  logic    trough_r, trough_nxt;
  rise_t   rise_r, rise_nxt;
  sample_t max_r, max_nxt;
  sample_t min_r, min_nxt;
  ms_t     ms_r, ms_nxt;
  rate_t   latest_r;

  // Result of the evaluation
  logic    res_fp_r, res_fp_nxt;
  logic    res_beat_r, res_beat_nxt;
  logic    res_valid_r, res_valid_nxt;
  logic    clear_rate;

  // Divider
  ms_t     dvs_r;
  rate_t   quo_r, quo_nxt;
  ms_t     rem_r, rem_nxt;
  logic [MS_BITS:0] shifted;

  // Output register
  logic    o_fp_r, o_beat_r, o_valid_r;
  rate_t   o_rate_r;

  logic [MS_BITS:0] ms_sum;
  ms_t     ms_sat;
  rise_t   rise_inc;
  logic    crest_tmp;
  logic    need_div;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RESET;
      crest_lvl_r  <= CREST_RESET;
      trough_lvl_r <= TROUGH_RESET;
      rise_need_r  <= RISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FINGER_THRESHOLD: thresh_r     <= cfg_data[RAW_BITS-1:0];
        CFG_CREST_LEVEL:      crest_lvl_r  <= sample_t'(cfg_data[SAMPLE_BITS-1:0]);
        CFG_TROUGH_LEVEL:     trough_lvl_r <= sample_t'(cfg_data[SAMPLE_BITS-1:0]);
        CFG_RISE_NEEDED:      rise_need_r  <= cfg_data[RISE_BITS-1:0];
        default:              thresh_r     <= thresh_r;
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r     <= in_raw_ir;
      data_r    <= in_filtered_ir;
      elapsed_r <= in_elapsed_ms;
    end
  end

  // Evaluate one sample against the detection state
  always_comb begin
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    crest_nxt      = crest_r;
    trough_nxt     = trough_r;
    rise_nxt       = rise_r;
    max_nxt        = max_r;
    min_nxt        = min_r;
    ms_nxt         = ms_r;
    res_fp_nxt     = 1'b1;
    res_beat_nxt   = 1'b0;
    res_valid_nxt  = 1'b1;
    clear_rate     = 1'b0;
    need_div       = 1'b0;
    crest_tmp      = crest_r;
    rise_inc       = (rise_r != '1) ? rise_r + rise_t'(1) : rise_r;
    ms_sum         = {1'b0, ms_r} + {1'b0, elapsed_r};
    ms_sat         = ms_sum[MS_BITS] ? '1 : ms_sum[MS_BITS-1:0];

    if (raw_r < thresh_r) begin
      // No finger: drop everything
      prev_nxt       = '0;
      prev_valid_nxt = 1'b0;
      crest_nxt      = 1'b0;
      trough_nxt     = 1'b0;
      rise_nxt       = '0;
      max_nxt        = RUN_MAX_INIT;
      min_nxt        = RUN_MIN_INIT;
      ms_nxt         = '0;
      clear_rate     = 1'b1;
      res_fp_nxt     = 1'b0;
      res_valid_nxt  = 1'b0;
    end else begin
      ms_nxt = ms_sat;
      if (prev_valid_r) begin
        if (crest_r && trough_r && (data_r > prev_r)) begin
          rise_nxt = rise_inc;
          if (rise_inc >= rise_need_r) begin
            res_beat_nxt = 1'b1;
            crest_nxt    = 1'b0;
            trough_nxt   = 1'b0;
            rise_nxt     = '0;
            max_nxt      = RUN_MAX_INIT;
            min_nxt      = RUN_MIN_INIT;
          end
        end
        if (!res_beat_nxt) begin
          // Track the crest, then the trough that follows it
          if (data_r > max_r) begin
            max_nxt = data_r;
            if (data_r > crest_lvl_r) crest_tmp = 1'b1;
          end
          crest_nxt = crest_tmp;
          if (crest_tmp && (data_r < min_r)) begin
            min_nxt = data_r;
            if (data_r < trough_lvl_r) trough_nxt = 1'b1;
          end
        end
      end
      if (res_beat_nxt) begin
        if (ms_sat == '0) res_valid_nxt = 1'b0;
        else need_div = 1'b1;
        ms_nxt = '0;
      end
      prev_nxt       = data_r;
      prev_valid_nxt = 1'b1;
    end
  end

  assign sts.need_div = need_div;

  // Restoring divider step: one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[RATE_BITS-1]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = MS_BITS'(shifted - {1'b0, dvs_r});
      quo_nxt = {quo_r[RATE_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[MS_BITS-1:0];
      quo_nxt = {quo_r[RATE_BITS-2:0], 1'b0};
    end
  end

  // Advance detection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      crest_r      <= 1'b0;
      trough_r     <= 1'b0;
      rise_r       <= '0;
      max_r        <= RUN_MAX_INIT;
      min_r        <= RUN_MIN_INIT;
      ms_r         <= '0;
      latest_r     <= '0;
    end else begin
      if (cmd.eval) begin
        prev_r       <= prev_nxt;
        prev_valid_r <= prev_valid_nxt;
        crest_r      <= crest_nxt;
        trough_r     <= trough_nxt;
        rise_r       <= rise_nxt;
        max_r        <= max_nxt;
        min_r        <= min_nxt;
        ms_r         <= ms_nxt;
        if (clear_rate) latest_r <= '0;
      end else if (cmd.div_last) begin
        latest_r <= quo_nxt;
      end
    end
  end

  // Hold the evaluation result and run the divider
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_fp_r    <= res_fp_nxt;
      res_beat_r  <= res_beat_nxt;
      res_valid_r <= res_valid_nxt;
      dvs_r       <= ms_sat;
      quo_r       <= RATE_DIVIDEND;
      rem_r       <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_fp_r    <= res_fp_r;
      o_beat_r  <= res_beat_r;
      o_rate_r  <= latest_r;
      o_valid_r <= res_valid_r;
    end
  end

  assign out_finger_present = o_fp_r;
  assign out_beat           = o_beat_r;
  assign out_beat_rate      = o_rate_r;
  assign out_rate_valid     = o_valid_r;

endmodule

>>> rtl/pbd_ctrl.sv
// ----------------------------------------------------------------------------
// PPG beat detector controller
// Sequences capture, evaluation, the rate division and the result hand-off.
// ----------------------------------------------------------------------------
module pbd_ctrl import pbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pbd_sts_t sts,
  output pbd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_free;
  logic                    div_last;

  assign out_free = !out_valid_r || out_ready;
  assign div_last = (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cnt_nxt  = '0;
        state_nxt = sts.need_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = div_last;
        cnt_nxt      = cnt_r + DIV_CNT_BITS'(1);
        if (div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("accepted word not evaluated next cycle");

  a_nodiv_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && !sts.need_div) |=> (state_r == ST_EMIT))
    else $error("word without division did not go to emit");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_last) |=> (state_r == ST_EMIT && cnt_r == '0))
    else $error("divider did not finish after its last step");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result shown without an emit");

endmodule

>>> rtl/ppg_beat_detect_rate.sv
// ----------------------------------------------------------------------------
// PPG beat detector and heart-rate estimator
// Crest/trough beat detection on the filtered IR signal, finger detection on
// the raw reading and a beat rate of 60000 / ms since the previous beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// in_ch     in   raw_ir[17:0], filtered_ir[19:0] signed, elapsed_ms[15:0]
// out_ch    out  finger_present, beat, beat_rate[15:0], rate_valid
// cfg_*     in   cfg_we, cfg_index[1:0], cfg_data[19:0], no read-back
//
// A word passes through capture, evaluate and emit; a beat with a non-zero
// interval adds a pass through the restoring divider, one quotient bit per step.
// A new word is taken once the previous one sits in the output register, so
// a result may wait for the sink while the next word is accepted.
// Emit stalls while the output register still holds an untaken result.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module ppg_beat_detect_rate import pbd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  pbd_in_if.sink                   in_ch,
  pbd_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  pbd_cmd_t cmd;
  pbd_sts_t sts;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_raw_ir          (in_ch.raw_ir),
    .in_filtered_ir     (in_ch.filtered_ir),
    .in_elapsed_ms      (in_ch.elapsed_ms),
    .cmd                (cmd),
    .sts                (sts),
    .out_finger_present (out_ch.finger_present),
    .out_beat           (out_ch.beat),
    .out_beat_rate      (out_ch.beat_rate),
    .out_rate_valid     (out_ch.rate_valid)
  );

endmodule
